/* hw/rtl/fdc_pkg.sv */
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants, codes and the byte-wide CRC-32 step for the frame
// deframer and CRC-32 checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

    localparam int HEADER_BYTES    = 20;
    localparam int MAX_FRAME_BYTES = 250;
    localparam int CRC_SPAN        = 16;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Status codes reported with the last beat of a frame.
    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_SHORT   = 4'd1;
    localparam logic [3:0] ERR_LONG    = 4'd2;
    localparam logic [3:0] ERR_MAGIC   = 4'd3;
    localparam logic [3:0] ERR_VERSION = 4'd4;
    localparam logic [3:0] ERR_FLAGS   = 4'd5;
    localparam logic [3:0] ERR_LENGTH  = 4'd6;
    localparam logic [3:0] ERR_CRC     = 4'd7;
    localparam logic [3:0] ERR_ACK     = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAGIC     = 3'd0;
    localparam logic [2:0] REG_VERSION   = 3'd1;
    localparam logic [2:0] REG_RELIABLE  = 3'd2;
    localparam logic [2:0] REG_ACK_MASK  = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;
    localparam logic [2:0] REG_ACK_ID    = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_MAGIC    = 16'd0;
    localparam logic [7:0]  RST_VERSION  = 8'd0;
    localparam logic [7:0]  RST_RELIABLE = 8'd1;
    localparam logic [7:0]  RST_ACK_MASK = 8'd2;
    localparam logic [7:0]  RST_LIMIT    = 8'd230;
    localparam logic [15:0] RST_ACK_ID   = 16'd0;

    // One byte of reflected CRC-32, unrolled over the eight bit steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/frame_deframer_crc32_check.sv */
// ----------------------------------------------------------------------------
// frame_deframer_crc32_check
// Byte-stream frame checker: captures the 20-byte header, passes payload
// bytes through and validates length, header fields, CRC-32 and ack rules.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in      | in        | in_valid / in_stall  | rx_byte, end_of_frame
//   out     | out       | out_valid / out_stall| payload and status fields
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// One byte is taken every cycle unless in_stall is high; each beat yields one
// result beat, registered in the input register and then the result register
// around the byte-wide CRC update and the status checks.
// Reset returns the configuration registers to their defaults and starts a
// new frame. A stall on the output holds the result register and stalls the
// input only when the input register is also full.
`default_nettype none

module frame_deframer_crc32_check
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        end_of_frame,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic             payload_strobe,
    output logic             frame_done,
    output logic             frame_ok,
    output logic [3:0]       error_code,
    output logic [7:0]       flag_bits,
    output logic [15:0]      msg_ident,
    output logic [15:0]      payload_length,
    output logic [31:0]      sequence_number,
    output logic [31:0]      correlation_value,

    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers.
    logic [15:0] magic_word_reg;
    logic [7:0]  version_byte_reg;
    logic [7:0]  reliable_mask_reg;
    logic [7:0]  ack_mask_reg;
    logic [7:0]  payload_limit_reg;
    logic [15:0] ack_id_reg;

    // Input register.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // Frame state.
    logic [7:0]  byte_index_reg,  byte_index_next;
    logic [31:0] crc_reg,         crc_next;
    logic [15:0] magic_reg,       magic_next;
    logic [7:0]  version_reg,     version_next;
    logic [7:0]  flags_reg,       flags_next;
    logic [15:0] msgid_reg,       msgid_next;
    logic [15:0] length_reg,      length_next;
    logic [31:0] sequence_reg,    sequence_next;
    logic [31:0] correlation_reg, correlation_next;
    logic [31:0] crc_field_reg,   crc_field_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  payload_byte_reg;
    logic        payload_strobe_reg;
    logic        frame_done_reg;
    logic        frame_ok_reg;
    logic [3:0]  error_code_reg;
    logic [7:0]  flag_bits_reg;
    logic [15:0] msg_ident_reg;
    logic [15:0] payload_length_reg;
    logic [31:0] sequence_number_reg;
    logic [31:0] correlation_value_reg;

    logic        in_accept;
    logic        advance;
    logic        in_payload;
    logic        in_crc_span;
    logic [8:0]  frame_len;
    logic [3:0]  err_code;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg    <= fdc_pkg::RST_MAGIC;
            version_byte_reg  <= fdc_pkg::RST_VERSION;
            reliable_mask_reg <= fdc_pkg::RST_RELIABLE;
            ack_mask_reg      <= fdc_pkg::RST_ACK_MASK;
            payload_limit_reg <= fdc_pkg::RST_LIMIT;
            ack_id_reg        <= fdc_pkg::RST_ACK_ID;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fdc_pkg::REG_MAGIC:    magic_word_reg    <= cfg_data;
                fdc_pkg::REG_VERSION:  version_byte_reg  <= cfg_data[7:0];
                fdc_pkg::REG_RELIABLE: reliable_mask_reg <= cfg_data[7:0];
                fdc_pkg::REG_ACK_MASK: ack_mask_reg      <= cfg_data[7:0];
                fdc_pkg::REG_LIMIT:    payload_limit_reg <= cfg_data[7:0];
                fdc_pkg::REG_ACK_ID:   ack_id_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= end_of_frame;
        end
    end

    // Header capture with the current beat folded in, so the checks on the
    // last beat see every byte that has arrived.
    always_comb
    begin
        magic_next       = magic_reg;
        version_next     = version_reg;
        flags_next       = flags_reg;
        msgid_next       = msgid_reg;
        length_next      = length_reg;
        sequence_next    = sequence_reg;
        correlation_next = correlation_reg;
        crc_field_next   = crc_field_reg;
        unique case (byte_index_reg)
            8'd0:  magic_next[7:0]         = s1_byte_reg;
            8'd1:  magic_next[15:8]        = s1_byte_reg;
            8'd2:  version_next            = s1_byte_reg;
            8'd3:  flags_next              = s1_byte_reg;
            8'd4:  msgid_next[7:0]         = s1_byte_reg;
            8'd5:  msgid_next[15:8]        = s1_byte_reg;
            8'd6:  length_next[7:0]        = s1_byte_reg;
            8'd7:  length_next[15:8]       = s1_byte_reg;
            8'd8:  sequence_next[7:0]      = s1_byte_reg;
            8'd9:  sequence_next[15:8]     = s1_byte_reg;
            8'd10: sequence_next[23:16]    = s1_byte_reg;
            8'd11: sequence_next[31:24]    = s1_byte_reg;
            8'd12: correlation_next[7:0]   = s1_byte_reg;
            8'd13: correlation_next[15:8]  = s1_byte_reg;
            8'd14: correlation_next[23:16] = s1_byte_reg;
            8'd15: correlation_next[31:24] = s1_byte_reg;
            8'd16: crc_field_next[7:0]     = s1_byte_reg;
            8'd17: crc_field_next[15:8]    = s1_byte_reg;
            8'd18: crc_field_next[23:16]   = s1_byte_reg;
            8'd19: crc_field_next[31:24]   = s1_byte_reg;
            default:
            begin
            end
        endcase
    end

    assign in_payload  = byte_index_reg >= 8'(fdc_pkg::HEADER_BYTES);
    assign in_crc_span = (byte_index_reg < 8'(fdc_pkg::CRC_SPAN)) || in_payload;
    assign crc_next    = in_crc_span ? fdc_pkg::crc32_byte(crc_reg, s1_byte_reg) : crc_reg;
    assign frame_len   = {1'b0, byte_index_reg} + 9'd1;

    assign byte_index_next = (byte_index_reg == 8'hFF) ? byte_index_reg
                                                        : byte_index_reg + 8'd1;

    always_comb
    begin
        priority if (frame_len < 9'(fdc_pkg::HEADER_BYTES))
        begin
            err_code = fdc_pkg::ERR_SHORT;
        end
        else if (frame_len > 9'(fdc_pkg::MAX_FRAME_BYTES))
        begin
            err_code = fdc_pkg::ERR_LONG;
        end
        else if (magic_next != magic_word_reg)
        begin
            err_code = fdc_pkg::ERR_MAGIC;
        end
        else if (version_next != version_byte_reg)
        begin
            err_code = fdc_pkg::ERR_VERSION;
        end
        else if ((flags_next & ~(reliable_mask_reg | ack_mask_reg)) != 8'd0)
        begin
            err_code = fdc_pkg::ERR_FLAGS;
        end
        else if ((length_next > {8'd0, payload_limit_reg}) ||
                 ({1'b0, length_next} + 17'(fdc_pkg::HEADER_BYTES) != {8'd0, frame_len}))
        begin
            err_code = fdc_pkg::ERR_LENGTH;
        end
        else if (crc_field_next != ~crc_next)
        begin
            err_code = fdc_pkg::ERR_CRC;
        end
        else if (((flags_next & ack_mask_reg) != 8'd0) &&
                 ((msgid_next != ack_id_reg) || (length_next != 16'd0) ||
                  ((flags_next & reliable_mask_reg) != 8'd0) ||
                  (correlation_next == 32'd0)))
        begin
            err_code = fdc_pkg::ERR_ACK;
        end
        else
        begin
            err_code = fdc_pkg::ERR_OK;
        end
    end

    // Frame state: updated per beat, cleared after the last beat of a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= 8'd0;
            crc_reg         <= fdc_pkg::CRC_INIT;
            magic_reg       <= 16'd0;
            version_reg     <= 8'd0;
            flags_reg       <= 8'd0;
            msgid_reg       <= 16'd0;
            length_reg      <= 16'd0;
            sequence_reg    <= 32'd0;
            correlation_reg <= 32'd0;
            crc_field_reg   <= 32'd0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                byte_index_reg  <= 8'd0;
                crc_reg         <= fdc_pkg::CRC_INIT;
                magic_reg       <= 16'd0;
                version_reg     <= 8'd0;
                flags_reg       <= 8'd0;
                msgid_reg       <= 16'd0;
                length_reg      <= 16'd0;
                sequence_reg    <= 32'd0;
                correlation_reg <= 32'd0;
                crc_field_reg   <= 32'd0;
            end
            else
            begin
                byte_index_reg  <= byte_index_next;
                crc_reg         <= crc_next;
                magic_reg       <= magic_next;
                version_reg     <= version_next;
                flags_reg       <= flags_next;
                msgid_reg       <= msgid_next;
                length_reg      <= length_next;
                sequence_reg    <= sequence_next;
                correlation_reg <= correlation_next;
                crc_field_reg   <= crc_field_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            payload_byte_reg      <= in_payload ? s1_byte_reg : 8'd0;
            payload_strobe_reg    <= in_payload;
            frame_done_reg        <= s1_last_reg;
            frame_ok_reg          <= s1_last_reg && (err_code == fdc_pkg::ERR_OK);
            error_code_reg        <= s1_last_reg ? err_code : fdc_pkg::ERR_OK;
            flag_bits_reg         <= s1_last_reg ? flags_next : 8'd0;
            msg_ident_reg         <= s1_last_reg ? msgid_next : 16'd0;
            payload_length_reg    <= s1_last_reg ? length_next : 16'd0;
            sequence_number_reg   <= s1_last_reg ? sequence_next : 32'd0;
            correlation_value_reg <= s1_last_reg ? correlation_next : 32'd0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign payload_byte      = payload_byte_reg;
    assign payload_strobe    = payload_strobe_reg;
    assign frame_done        = frame_done_reg;
    assign frame_ok          = frame_ok_reg;
    assign error_code        = error_code_reg;
    assign flag_bits         = flag_bits_reg;
    assign msg_ident         = msg_ident_reg;
    assign payload_length    = payload_length_reg;
    assign sequence_number   = sequence_number_reg;
    assign correlation_value = correlation_value_reg;

endmodule

`default_nettype wire
